// ----- sv/sst_pkg.sv -----
// Shared types and constants for the scoped symbol table.
// Holds command and status codes, port field widths and the
// controller/datapath handshake structs. No dependencies.
`default_nettype none

package sst_pkg;

  localparam int CMD_W     = 2;
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int DEPTH_W   = 5;

  localparam int DEF_MAX_ENTRIES  = 64;
  localparam int DEF_MAX_SCOPES   = 16;
  localparam int DEF_KEY_BITS     = 32;
  localparam int DEF_PAYLOAD_BITS = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_OPEN   = 2'd2,
    CMD_CLOSE  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_MISS      = 3'd2,
    ST_FULL      = 3'd3,
    ST_SCOPE_OVF = 3'd4,
    ST_NO_SCOPE  = 3'd5
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    mark_rd;
    logic    mark_wr;
    logic    close_pop;
    logic    scan_init;
    logic    scan_step;
    logic    entry_wr;
    logic    load_out;
    logic    pay_sel;
    status_t status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic scope_empty;
    logic scope_full;
    logic table_full;
    logic more;
    logic pend;
    logic hit;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/sst_if.sv -----
// Valid/ready channel interfaces for the scoped symbol table.
// Depends on sst_pkg for the field widths.
`default_nettype none

interface sst_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [sst_pkg::CMD_W-1:0]   command;
  logic [sst_pkg::KEY_W-1:0]   key;
  logic [sst_pkg::PAY_W-1:0]   payload;

  modport source (output valid, command, key, payload, input ready);
  modport sink   (input valid, command, key, payload, output ready);
endinterface

interface sst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sst_pkg::STATUS_W-1:0]  status;
  logic [sst_pkg::PAY_W-1:0]     found_payload;
  logic [sst_pkg::DEPTH_W-1:0]   scope_depth;

  modport source (output valid, status, found_payload, scope_depth, input ready);
  modport sink   (input valid, status, found_payload, scope_depth, output ready);
endinterface

`default_nettype wire

// ----- sv/scoped_symbol_table.sv -----
// Top level of the scoped symbol table: controller plus datapath.
// Depends on sst_pkg, sst_if, sst_ctrl and sst_datapath.
`default_nettype none

// A symbol table with nested scopes that takes one command per transfer on
// cmd and returns one result per command on rsp. Commands are handled one at
// a time. Lookups and inserts sweep the single read port of the entry store
// one entry per cycle, newest first (all stored entries for a lookup, the
// innermost scope for an insert); the scan stops at the first match. A
// finished result sits in the output register while the next command is
// accepted and decoded. The stores need no clearing after reset.
module scoped_symbol_table #(
  parameter int MAX_ENTRIES  = sst_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_SCOPES   = sst_pkg::DEF_MAX_SCOPES,
  parameter int KEY_BITS     = sst_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = sst_pkg::DEF_PAYLOAD_BITS
) (
  input wire logic  clk,
  input wire logic  rst,
  sst_cmd_if.sink   cmd,
  sst_rsp_if.source rsp
);

  sst_pkg::ctrl_cmd_t ctl;
  sst_pkg::dp_status_t dp_st;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .st        (dp_st),
    .ctl       (ctl)
  );

  sst_datapath #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_SCOPES   (MAX_SCOPES),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .command       (cmd.command),
    .key           (cmd.key),
    .payload       (cmd.payload),
    .ctl           (ctl),
    .st            (dp_st),
    .status        (rsp.status),
    .found_payload (rsp.found_payload),
    .scope_depth   (rsp.scope_depth)
  );

  // A new entry is never written into a full table.
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    ctl.entry_wr |-> !dp_st.table_full)
    else $error("entry written while the table is full");

  // A scope is never pushed beyond the stack depth.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    ctl.mark_wr |-> !dp_st.scope_full)
    else $error("scope mark pushed while the stack is full");

  // Only a successful command can carry a nonzero payload.
  a_payload_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != sst_pkg::ST_OK)) |-> (rsp.found_payload == '0))
    else $error("nonzero payload on a failed command");

  // Once a command transfers, the port stays closed while it is processed.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command accepted while another is in progress");

endmodule

`default_nettype wire

// ----- sv/sst_datapath.sv -----
// Datapath of the scoped symbol table: entry stores, scope mark stack,
// scan pointer with registered reads, counters and the result register.
// Depends on sst_pkg.
`default_nettype none

module sst_datapath #(
  parameter int MAX_ENTRIES  = sst_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_SCOPES   = sst_pkg::DEF_MAX_SCOPES,
  parameter int KEY_BITS     = sst_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = sst_pkg::DEF_PAYLOAD_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [sst_pkg::CMD_W-1:0]     command,
  input  wire logic [sst_pkg::KEY_W-1:0]     key,
  input  wire logic [sst_pkg::PAY_W-1:0]     payload,
  input  wire sst_pkg::ctrl_cmd_t            ctl,
  output sst_pkg::dp_status_t                st,
  output logic [sst_pkg::STATUS_W-1:0]       status,
  output logic [sst_pkg::PAY_W-1:0]          found_payload,
  output logic [sst_pkg::DEPTH_W-1:0]        scope_depth
);

  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int SAW = (MAX_SCOPES > 1) ? $clog2(MAX_SCOPES) : 1;
  localparam int SCW = $clog2(MAX_SCOPES + 1);
  localparam int KW  = (KEY_BITS < sst_pkg::KEY_W) ? KEY_BITS : sst_pkg::KEY_W;
  localparam int PW  = (PAYLOAD_BITS < sst_pkg::PAY_W) ? PAYLOAD_BITS : sst_pkg::PAY_W;

  logic [KW-1:0]  key_mem [MAX_ENTRIES];
  logic [PW-1:0]  pay_mem [MAX_ENTRIES];
  logic [CW-1:0]  mark_mem [MAX_SCOPES];

  sst_pkg::cmd_t  cmd_r;
  logic [KW-1:0]  key_r;
  logic [PW-1:0]  pay_r;

  logic [CW-1:0]  entry_count;
  logic [SCW-1:0] open_scopes;
  logic [SCW-1:0] open_dec;
  logic [CW-1:0]  mark_q;

  logic [CW-1:0]  ptr;
  logic [CW-1:0]  ptr_dec;
  logic [CW-1:0]  low;
  logic           pend;
  logic           rd_en;
  logic [KW-1:0]  key_q;
  logic [PW-1:0]  pay_q;

  assign open_dec = open_scopes - 1'b1;
  assign ptr_dec  = ptr - 1'b1;
  // Inserts only check the innermost scope; lookups search the whole table.
  assign low      = (cmd_r == sst_pkg::CMD_INSERT) ? mark_q : '0;

  always_comb begin
    st.cmd         = cmd_r;
    st.scope_empty = (open_scopes == '0);
    st.scope_full  = (open_scopes == SCW'(MAX_SCOPES));
    st.table_full  = (entry_count == CW'(MAX_ENTRIES));
    st.more        = (ptr != low);
    st.pend        = pend;
    st.hit         = pend && (key_q == key_r);
  end

  // A hit freezes the read registers so the matched payload stays available.
  assign rd_en = ctl.scan_step && st.more && !st.hit;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r <= sst_pkg::cmd_t'(command);
      key_r <= key[KW-1:0];
      pay_r <= payload[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.entry_wr) begin
      key_mem[entry_count[AW-1:0]] <= key_r;
      pay_mem[entry_count[AW-1:0]] <= pay_r;
    end
    if (rd_en) begin
      key_q <= key_mem[ptr_dec[AW-1:0]];
      pay_q <= pay_mem[ptr_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mark_wr) begin
      mark_mem[open_scopes[SAW-1:0]] <= entry_count;
    end
    if (ctl.mark_rd) begin
      mark_q <= mark_mem[open_dec[SAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      open_scopes <= '0;
      pend        <= 1'b0;
    end else begin
      if (ctl.entry_wr) begin
        entry_count <= entry_count + 1'b1;
      end else if (ctl.close_pop) begin
        entry_count <= mark_q;
      end
      if (ctl.mark_wr) begin
        open_scopes <= open_scopes + 1'b1;
      end else if (ctl.close_pop) begin
        open_scopes <= open_dec;
      end
      if (ctl.scan_init) begin
        pend <= 1'b0;
      end else if (ctl.scan_step) begin
        pend <= rd_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_init) begin
      ptr <= entry_count;
    end else if (rd_en) begin
      ptr <= ptr_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      status        <= ctl.status;
      found_payload <= ctl.pay_sel ? sst_pkg::PAY_W'(pay_q) : '0;
      scope_depth   <= sst_pkg::DEPTH_W'(open_scopes);
    end
  end

endmodule

`default_nettype wire

// ----- sv/sst_ctrl.sv -----
// Controller of the scoped symbol table: one-hot state machine that
// sequences decode, scope mark access, entry scan and result transfer.
// Depends on sst_pkg.
`default_nettype none

module sst_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire sst_pkg::dp_status_t  st,
  output sst_pkg::ctrl_cmd_t        ctl
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_MARK   = 5'b00100,
    S_SCAN   = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t           state;
  state_t           state_next;
  sst_pkg::status_t code;
  sst_pkg::status_t code_next;
  logic             sel;
  logic             sel_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    code_next  = code;
    sel_next   = sel;
    ctl.status  = code;
    ctl.pay_sel = sel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        sel_next = 1'b0;
        case (st.cmd)
          sst_pkg::CMD_INSERT, sst_pkg::CMD_CLOSE: begin
            if (st.scope_empty) begin
              code_next  = sst_pkg::ST_NO_SCOPE;
              state_next = S_RESP;
            end else begin
              ctl.mark_rd = 1'b1;
              state_next  = S_MARK;
            end
          end
          sst_pkg::CMD_LOOKUP: begin
            ctl.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
          sst_pkg::CMD_OPEN: begin
            if (st.scope_full) begin
              code_next = sst_pkg::ST_SCOPE_OVF;
            end else begin
              ctl.mark_wr = 1'b1;
              code_next   = sst_pkg::ST_OK;
            end
            state_next = S_RESP;
          end
          default: begin
            code_next  = sst_pkg::ST_NO_SCOPE;
            state_next = S_RESP;
          end
        endcase
      end
      S_MARK: begin
        if (st.cmd == sst_pkg::CMD_INSERT) begin
          ctl.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          ctl.close_pop = 1'b1;
          code_next     = sst_pkg::ST_OK;
          state_next    = S_RESP;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (st.hit) begin
          if (st.cmd == sst_pkg::CMD_LOOKUP) begin
            code_next = sst_pkg::ST_OK;
            sel_next  = 1'b1;
          end else begin
            code_next = sst_pkg::ST_DUP;
          end
          state_next = S_RESP;
        end else if (!st.more && !st.pend) begin
          if (st.cmd == sst_pkg::CMD_LOOKUP) begin
            code_next = sst_pkg::ST_MISS;
          end else if (st.table_full) begin
            code_next = sst_pkg::ST_FULL;
          end else begin
            ctl.entry_wr = 1'b1;
            code_next    = sst_pkg::ST_OK;
          end
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    code <= code_next;
    sel  <= sel_next;
  end

endmodule

`default_nettype wire
